[rtl/mbr_pkg.sv]
// ----------------------------------------------------------------------------
// mbr_pkg
// Shared types and constants for the matrix element / bias / ReLU block.
// ----------------------------------------------------------------------------
package mbr_pkg;

    localparam int MBR_MAX_DIM    = 16;
    localparam int MBR_ELEM_WIDTH = 32;

    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 32;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(16);

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DEPTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_BIAS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_APPLY_RELU  = 3'd4;

    typedef enum logic [1:0] {
        OP_LOAD_A    = 2'd0,
        OP_LOAD_B    = 2'd1,
        OP_LOAD_BIAS = 2'd2,
        OP_COMPUTE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic capture;
        logic issue;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic compute_go;
        logic depth_zero;
        logic last_issue;
        logic pipe_busy;
    } dp_status_t;

endpackage

[rtl/mbr_ram.sv]
// ----------------------------------------------------------------------------
// mbr_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mbr_ctrl.sv]
// ----------------------------------------------------------------------------
// mbr_ctrl
// Sequencer: accepts requests, walks the inner dimension, finishes the result.
// ----------------------------------------------------------------------------
module mbr_ctrl
    import mbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = start;
                if (start && status.compute_go)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.depth_zero ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[rtl/mbr_dp.sv]
// ----------------------------------------------------------------------------
// mbr_dp
// Datapath: configuration, element stores, address walk, split multiplier,
// accumulator, bias and ReLU, result register.
// ----------------------------------------------------------------------------
module mbr_dp
    import mbr_pkg::*;
#(
    parameter int MAX_DIM    = MBR_MAX_DIM,
    parameter int ELEM_WIDTH = MBR_ELEM_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata,
    input  logic [1:0]              op,
    input  logic [IDX_W-1:0]        row_index,
    input  logic [IDX_W-1:0]        col_index,
    input  logic signed [VAL_W-1:0] value,
    input  ctrl_cmd_t               cmd,
    output dp_status_t              status,
    output logic                    done,
    output logic [IDX_W-1:0]        out_row,
    output logic [IDX_W-1:0]        out_col,
    output logic signed [VAL_W-1:0] result
);

    localparam int W   = ELEM_WIDTH;
    localparam int H   = (W + 1) / 2;
    localparam int L   = W - H;
    localparam int AW  = $clog2(MAX_DIM * MAX_DIM);
    localparam int BW  = $clog2(MAX_DIM);
    localparam int KW  = $clog2(MAX_DIM);
    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int CW  = (DW > CFG_W) ? DW : CFG_W;

    // configuration
    logic [CFG_W-1:0] out_rows_reg;
    logic [CFG_W-1:0] out_cols_reg;
    logic [CFG_W-1:0] inner_depth_reg;
    logic             add_bias_reg;
    logic             apply_relu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_rows_reg    <= SIZE_RESET;
            out_cols_reg    <= SIZE_RESET;
            inner_depth_reg <= SIZE_RESET;
            add_bias_reg    <= 1'b0;
            apply_relu_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_OUT_ROWS:    out_rows_reg    <= cfg_wdata;
                CFG_OUT_COLS:    out_cols_reg    <= cfg_wdata;
                CFG_INNER_DEPTH: inner_depth_reg <= cfg_wdata;
                CFG_ADD_BIAS:    add_bias_reg    <= cfg_wdata[0];
                CFG_APPLY_RELU:  apply_relu_reg  <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // size limits, saturated to the store dimension
    logic [CW-1:0] rows_lim;
    logic [CW-1:0] cols_lim;
    logic [CW-1:0] depth_sat;
    logic [DW-1:0] depth_lim;
    logic [CW-1:0] row_cw;
    logic [CW-1:0] col_cw;
    logic          row_in_store;
    logic          col_in_store;

    assign rows_lim  = (CW'(out_rows_reg) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(out_rows_reg);
    assign cols_lim  = (CW'(out_cols_reg) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(out_cols_reg);
    assign depth_sat = (CW'(inner_depth_reg) > CW'(MAX_DIM)) ?
                       CW'(MAX_DIM) : CW'(inner_depth_reg);
    assign depth_lim = DW'(depth_sat);

    assign row_cw       = CW'(row_index);
    assign col_cw       = CW'(col_index);
    assign row_in_store = (row_cw < CW'(MAX_DIM));
    assign col_in_store = (col_cw < CW'(MAX_DIM));

    assign status.compute_go = (op == OP_COMPUTE) && (row_cw < rows_lim) && (col_cw < cols_lim);
    assign status.depth_zero = (depth_lim == '0);

    // load requests
    logic [AW-1:0] row_base;
    logic [AW-1:0] load_addr;
    logic [W-1:0]  load_val;
    logic          we_a;
    logic          we_b;
    logic          we_bias;

    assign row_base  = AW'(AW'(row_index) * AW'(MAX_DIM));
    assign load_addr = AW'(row_base + AW'(col_index));
    assign load_val  = W'(value);

    always_comb
    begin
        we_a    = 1'b0;
        we_b    = 1'b0;
        we_bias = 1'b0;
        if (cmd.accept)
        begin
            unique case (op)
                OP_LOAD_A:    we_a    = row_in_store && col_in_store;
                OP_LOAD_B:    we_b    = row_in_store && col_in_store;
                OP_LOAD_BIAS: we_bias = col_in_store;
                default:      ;
            endcase
        end
    end

    // address walk over the inner dimension
    logic [AW-1:0]    a_addr_reg;
    logic [AW-1:0]    b_addr_reg;
    logic [KW-1:0]    k_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] col_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_addr_reg <= row_base;
            b_addr_reg <= AW'(col_index);
            k_reg      <= '0;
            row_reg    <= row_index;
            col_reg    <= col_index;
        end
        else if (cmd.issue)
        begin
            a_addr_reg <= AW'(a_addr_reg + AW'(1));
            b_addr_reg <= AW'(b_addr_reg + AW'(MAX_DIM));
            k_reg      <= KW'(k_reg + KW'(1));
        end
    end

    assign status.last_issue = (DW'(k_reg) + DW'(1)) == depth_lim;

    // stores
    logic [W-1:0]  a_rdata;
    logic [W-1:0]  b_rdata;
    logic [W-1:0]  bias_rdata;
    logic [BW-1:0] bias_raddr;

    assign bias_raddr = cmd.capture ? BW'(col_index) : BW'(col_reg);

    mbr_ram #(
        .WIDTH (W),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_a_store (
        .clk   (clk),
        .we    (we_a),
        .waddr (load_addr),
        .wdata (load_val),
        .raddr (a_addr_reg),
        .rdata (a_rdata)
    );

    mbr_ram #(
        .WIDTH (W),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_b_store (
        .clk   (clk),
        .we    (we_b),
        .waddr (load_addr),
        .wdata (load_val),
        .raddr (b_addr_reg),
        .rdata (b_rdata)
    );

    mbr_ram #(
        .WIDTH (W),
        .DEPTH (MAX_DIM)
    ) u_bias_store (
        .clk   (clk),
        .we    (we_bias),
        .waddr (BW'(col_index)),
        .wdata (load_val),
        .raddr (bias_raddr),
        .rdata (bias_rdata)
    );

    // multiply-accumulate pipeline: read, partial products, product, accumulate
    logic           rd_v_reg;
    logic           pp_v_reg;
    logic           pr_v_reg;
    logic [2*H-1:0] m0;
    logic [L-1:0]   m1a;
    logic [L-1:0]   m1b;
    logic [W-1:0]   p0_reg;
    logic [L-1:0]   p1a_reg;
    logic [L-1:0]   p1b_reg;
    logic [W-1:0]   prod_reg;
    logic [W-1:0]   acc_reg;
    logic [W-1:0]   acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            pp_v_reg <= 1'b0;
            pr_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.issue;
            pp_v_reg <= rd_v_reg;
            pr_v_reg <= pp_v_reg;
        end
    end

    assign status.pipe_busy = rd_v_reg || pp_v_reg || pr_v_reg;

    // low W bits of the product from half-width pieces
    assign m0  = a_rdata[H-1:0] * b_rdata[H-1:0];
    assign m1a = L'(a_rdata[H-1:0] * H'(b_rdata[W-1:H]));
    assign m1b = L'(H'(a_rdata[W-1:H]) * b_rdata[H-1:0]);

    always_ff @(posedge clk)
    begin
        p0_reg   <= m0[W-1:0];
        p1a_reg  <= m1a;
        p1b_reg  <= m1b;
        prod_reg <= W'(p0_reg + {L'(p1a_reg + p1b_reg), {H{1'b0}}});
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.capture)
        begin
            acc_next = '0;
        end
        else if (pr_v_reg)
        begin
            acc_next = W'(acc_reg + prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // bias, ReLU, result
    logic [W-1:0] biased;
    logic [W-1:0] final_val;
    logic         done_reg;
    logic [IDX_W-1:0] out_row_reg;
    logic [IDX_W-1:0] out_col_reg;
    logic [VAL_W-1:0] result_reg;

    assign biased    = add_bias_reg ? W'(acc_reg + bias_rdata) : acc_reg;
    assign final_val = (apply_relu_reg && biased[W-1]) ? '0 : biased;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
            result_reg  <= VAL_W'(final_val);
        end
    end

    assign done    = done_reg;
    assign out_row = out_row_reg;
    assign out_col = out_col_reg;
    assign result  = result_reg;

endmodule

[rtl/matmul_bias_relu.sv]
// ----------------------------------------------------------------------------
// matmul_bias_relu
// One element of C = A*B with optional per-column bias and optional ReLU.
//
// Requests enter on start/op/row_index/col_index/value and are taken at a
// clock edge with start high and busy low. Loads (A, B, bias) write one
// store entry; busy stays low. A compute request outside the configured
// size gives no result, and busy stays low too. An in-range compute
// request raises busy while it walks the inner dimension: one element
// pair per cycle through the store read ports and the single
// multiply-accumulate pipeline (read, partial products, product, add),
// then a drain of the pipeline and the bias/ReLU state. With inner_depth
// zero only the bias/ReLU state remains and busy is high for one cycle.
// done is registered from the bias/ReLU state, rises once busy is low
// again and stays high for exactly one cycle; the next request can be
// taken in that cycle.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata, to be written only while
// idle (not enforced by the block). Reset: sizes go to 16, bias and ReLU
// off, the machine to idle; store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module matmul_bias_relu
    import mbr_pkg::*;
#(
    parameter int MAX_DIM    = MBR_MAX_DIM,
    parameter int ELEM_WIDTH = MBR_ELEM_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              op,
    input  logic [IDX_W-1:0]        row_index,
    input  logic [IDX_W-1:0]        col_index,
    input  logic signed [VAL_W-1:0] value,
    output logic                    done,
    output logic [IDX_W-1:0]        out_row,
    output logic [IDX_W-1:0]        out_col,
    output logic signed [VAL_W-1:0] result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mbr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mbr_dp #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .op        (op),
        .row_index (row_index),
        .col_index (col_index),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .out_row   (out_row),
        .out_col   (out_col),
        .result    (result)
    );

endmodule
